// File: sv/sfd_pkg.sv
// shared types, codes and the crc step for the stuffed frame decoder
package sfd_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h6F63;
  localparam logic [7:0]  STUFF_MASK = 8'h20;

  // configuration register indexes
  localparam logic [7:0] REG_START_CHAR  = 8'd0;
  localparam logic [7:0] REG_END_CHAR    = 8'd1;
  localparam logic [7:0] REG_ESCAPE_CHAR = 8'd2;
  localparam logic [7:0] REG_MAX_PAYLOAD = 8'd3;

  // verdict status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_TRUNC = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_ESC   = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;
  localparam logic [2:0] ST_CRC   = 3'd6;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       last_byte;
  } sfd_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic [7:0]  payload_length;
    logic [2:0]  status;
  } sfd_out_t;

  // one byte of crc-16, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: sv/stuffed_frame_decoder_crc16.sv
// byte-stuffed frame decoder with crc-16 check and output skid buffer
// a result is registered into the output register, or into the skid register while the sink stalls
// throughput: one byte per cycle while in_stall is low; the per-byte crc step and phase update are in the same cycle
// in_stall rises only while the skid register holds a second result the sink has not taken
// rst_n (synchronous) restores the delimiter defaults, clears the frame state and empties
// the output and skid registers
module stuffed_frame_decoder_crc16 import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  sfd_in_t    in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output sfd_out_t   out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_SRC_HI = 4'd1;
  localparam logic [3:0] PH_SRC_LO = 4'd2;
  localparam logic [3:0] PH_DST_HI = 4'd3;
  localparam logic [3:0] PH_DST_LO = 4'd4;
  localparam logic [3:0] PH_LEN    = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_CRC_HI = 4'd7;
  localparam logic [3:0] PH_CRC_LO = 4'd8;
  localparam logic [3:0] PH_END    = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;
  localparam logic [3:0] PH_ERROR  = 4'd11;

  logic [7:0]  start_char_r, end_char_r, escape_char_r, max_payload_r;

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] src_r, src_nxt;
  logic [15:0] dst_r, dst_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        emit;
  logic [7:0]  data_byte;
  logic [7:0]  unstuffed;
  logic [7:0]  b;
  logic [2:0]  verdict_st;
  logic        acc;
  logic        res_v;
  sfd_out_t    res;

  sfd_out_t    out_r, skid_r;
  logic        out_v_r, skid_v_r;
  logic        out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r  <= 8'd123;
      end_char_r    <= 8'd124;
      escape_char_r <= 8'd125;
      max_payload_r <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_CHAR:  start_char_r  <= cfg_data;
        REG_END_CHAR:    end_char_r    <= cfg_data;
        REG_ESCAPE_CHAR: escape_char_r <= cfg_data;
        REG_MAX_PAYLOAD: max_payload_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign acc       = in_valid && !skid_v_r;
  assign in_stall  = skid_v_r;
  assign b         = in_item.raw_byte;
  assign unstuffed = b ^ STUFF_MASK;

  // per-byte frame parsing
  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    esc_nxt    = esc_r;
    crc_hi_nxt = crc_hi_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    data_byte  = b;
    unique case (phase_r)
      PH_START: begin
        if (b == start_char_r) begin
          phase_nxt = PH_SRC_HI;
        end else begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_START;
        end
      end
      PH_SRC_HI: begin
        src_nxt   = {b, 8'h00};
        phase_nxt = PH_SRC_LO;
      end
      PH_SRC_LO: begin
        src_nxt   = {src_r[15:8], b};
        phase_nxt = PH_DST_HI;
      end
      PH_DST_HI: begin
        dst_nxt   = {b, 8'h00};
        phase_nxt = PH_DST_LO;
      end
      PH_DST_LO: begin
        dst_nxt   = {dst_r[15:8], b};
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = b;
        if (b > max_payload_r) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_LEN;
        end else if (b == 8'd0) begin
          phase_nxt = PH_CRC_HI;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          if (unstuffed == start_char_r || unstuffed == end_char_r ||
              unstuffed == escape_char_r) begin
            emit      = 1'b1;
            data_byte = unstuffed;
          end else begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_ESC;
          end
        end else if (b == escape_char_r) begin
          esc_nxt = 1'b1;
        end else begin
          emit = 1'b1;
        end
        if (emit) begin
          crc_nxt   = crc_byte(crc_r, data_byte);
          count_nxt = count_r + 8'd1;
          if (count_nxt == len_r) phase_nxt = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        crc_hi_nxt = b;
        phase_nxt  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        // zero left over means the received crc matches
        crc_nxt   = crc_r ^ {crc_hi_r, b};
        phase_nxt = PH_END;
      end
      PH_END: begin
        if (b != end_char_r) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_END;
        end else if (crc_r != 16'd0) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_CRC;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_ERROR;
        err_nxt   = ST_TRUNC;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (err_nxt != ST_OK) verdict_st = err_nxt;
    else if (phase_nxt == PH_DONE) verdict_st = ST_OK;
    else verdict_st = ST_TRUNC;
  end

  always_comb begin
    res = '0;
    if (in_item.last_byte) begin
      res.kind           = KIND_VERDICT;
      res.source_address = src_nxt;
      res.dest_address   = dst_nxt;
      res.payload_length = len_nxt;
      res.status         = verdict_st;
    end else begin
      res.kind         = KIND_DATA;
      res.payload_byte = data_byte;
    end
  end

  assign res_v = acc && (in_item.last_byte || emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      crc_r    <= CRC_INIT;
      src_r    <= '0;
      dst_r    <= '0;
      len_r    <= '0;
      count_r  <= '0;
      esc_r    <= 1'b0;
      crc_hi_r <= '0;
      err_r    <= ST_OK;
    end else if (acc) begin
      if (in_item.last_byte) begin
        phase_r  <= PH_START;
        crc_r    <= CRC_INIT;
        src_r    <= '0;
        dst_r    <= '0;
        len_r    <= '0;
        count_r  <= '0;
        esc_r    <= 1'b0;
        crc_hi_r <= '0;
        err_r    <= ST_OK;
      end else begin
        phase_r  <= phase_nxt;
        crc_r    <= crc_nxt;
        src_r    <= src_nxt;
        dst_r    <= dst_nxt;
        len_r    <= len_nxt;
        count_r  <= count_nxt;
        esc_r    <= esc_nxt;
        crc_hi_r <= crc_hi_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  // output register with one skid entry behind it
  assign out_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= res_v;
      end
    end else if (res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) out_r <= skid_r;
      else if (res_v) out_r <= res;
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while output register empty");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_item.last_byte) |=> (phase_r == PH_START && err_r == ST_OK && crc_r == CRC_INIT))
    else $error("frame state not cleared after a verdict");

  a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERROR) |-> (err_r != ST_OK))
    else $error("error phase without an error code");

  a_data_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.kind == KIND_DATA) |->
      (out_r.status == ST_OK && out_r.source_address == 16'd0 &&
       out_r.dest_address == 16'd0 && out_r.payload_length == 8'd0))
    else $error("payload item carries verdict fields");

endmodule

// File: tb/sv/stuffed_frame_decoder_crc16_tb.sv
// self-checking testbench for the byte-stuffed frame decoder with crc-16
`timescale 1ns / 1ps

module stuffed_frame_decoder_crc16_tb import sfd_pkg::*; ();

  localparam int DRAIN_LIMIT = 50000;
  localparam int LONG_HOLD   = 120;
  // an index outside the register map, which the block ignores
  localparam logic [7:0] REG_SPARE = 8'd200;

  typedef enum logic [3:0] {
    FR_START, FR_SRC_HI, FR_SRC_LO, FR_DST_HI, FR_DST_LO, FR_LEN,
    FR_DATA, FR_CRC_HI, FR_CRC_LO, FR_END, FR_DONE, FR_ERROR
  } frame_phase_t;

  typedef enum {
    FL_NONE, FL_START, FL_LEN, FL_ESC, FL_END, FL_CRC, FL_TRUNC, FL_LONG, FL_NOISE
  } frame_fault_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  sfd_in_t    in_item   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;
  logic       in_stall;
  logic       out_valid;
  logic       cfg_ready;
  sfd_out_t   out_item;

  stuffed_frame_decoder_crc16 DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // register copies
  logic [7:0] cfg_start  = 8'd123;
  logic [7:0] cfg_end    = 8'd124;
  logic [7:0] cfg_escape = 8'd125;
  logic [7:0] cfg_max    = 8'd255;

  // decoder state as the block should hold it
  frame_phase_t fr_phase;
  logic [15:0]  crc_acc;
  logic [15:0]  src_word;
  logic [15:0]  dst_word;
  logic [7:0]   len_byte;
  logic [7:0]   data_count;
  logic         esc_open;
  logic [7:0]   crc_hi_byte;
  logic [2:0]   first_error;

  sfd_in_t  raw_bytes[$];
  sfd_out_t frame_outputs[$];

  bit in_took   = 1'b0;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;
  int hold_left  = 0;
  int bytes_queued   = 0;
  int bytes_accepted = 0;
  int outputs_seen   = 0;
  int settings_used  = 0;
  int fail_count     = 0;

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void clear_frame_state();
    fr_phase    = FR_START;
    crc_acc     = CRC_INIT;
    src_word    = '0;
    dst_word    = '0;
    len_byte    = '0;
    data_count  = '0;
    esc_open    = 1'b0;
    crc_hi_byte = '0;
    first_error = ST_OK;
  endfunction

  function automatic void abort_frame(input logic [2:0] code);
    first_error = code;
    fr_phase = FR_ERROR;
  endfunction

  function automatic bit is_special(input logic [7:0] d);
    return d == cfg_start || d == cfg_end || d == cfg_escape;
  endfunction

  function automatic void absorb_data(input logic [7:0] d);
    crc_acc = crc16_step(crc_acc, d);
    data_count++;
    if (data_count == len_byte) fr_phase = FR_CRC_HI;
  endfunction

  function automatic void decode_byte(input sfd_in_t it, output bit produced,
                                      output sfd_out_t res);
    logic [7:0] b;
    logic [7:0] d;
    logic [7:0] data;
    bit         emit;
    b = it.raw_byte;
    d = '0;
    data = '0;
    emit = 1'b0;
    case (fr_phase)
      FR_START: begin
        if (b == cfg_start) fr_phase = FR_SRC_HI;
        else abort_frame(ST_START);
      end
      FR_SRC_HI: begin
        src_word = {b, 8'h00};
        fr_phase = FR_SRC_LO;
      end
      FR_SRC_LO: begin
        src_word[7:0] = b;
        fr_phase = FR_DST_HI;
      end
      FR_DST_HI: begin
        dst_word = {b, 8'h00};
        fr_phase = FR_DST_LO;
      end
      FR_DST_LO: begin
        dst_word[7:0] = b;
        fr_phase = FR_LEN;
      end
      FR_LEN: begin
        len_byte = b;
        if (b > cfg_max) abort_frame(ST_LEN);
        else fr_phase = (b == 8'd0) ? FR_CRC_HI : FR_DATA;
      end
      FR_DATA: begin
        if (esc_open) begin
          d = b ^ STUFF_MASK;
          esc_open = 1'b0;
          if (is_special(d)) begin
            data = d;
            emit = 1'b1;
            absorb_data(d);
          end else begin
            abort_frame(ST_ESC);
          end
        end else if (b == cfg_escape) begin
          esc_open = 1'b1;
        end else begin
          data = b;
          emit = 1'b1;
          absorb_data(b);
        end
      end
      FR_CRC_HI: begin
        crc_hi_byte = b;
        fr_phase = FR_CRC_LO;
      end
      FR_CRC_LO: begin
        // zero left over means the received crc matched
        crc_acc = crc_acc ^ {crc_hi_byte, b};
        fr_phase = FR_END;
      end
      FR_END: begin
        if (b != cfg_end) abort_frame(ST_END);
        else if (crc_acc != 16'd0) abort_frame(ST_CRC);
        else fr_phase = FR_DONE;
      end
      FR_DONE: abort_frame(ST_TRUNC);
      default: ;
    endcase
    res = '0;
    produced = 1'b0;
    if (it.last_byte) begin
      res.kind = KIND_VERDICT;
      res.source_address = src_word;
      res.dest_address = dst_word;
      res.payload_length = len_byte;
      res.status = (first_error != ST_OK) ? first_error :
                   (fr_phase == FR_DONE) ? ST_OK : ST_TRUNC;
      produced = 1'b1;
      clear_frame_state();
    end else if (emit) begin
      res.kind = KIND_DATA;
      res.payload_byte = data;
      produced = 1'b1;
    end
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // item driver
  always @(negedge clk) begin
    logic    v;
    sfd_in_t it;
    v = in_valid;
    it = in_item;
    if (!rst_n) begin
      v = 1'b0;
    end else if (!in_valid || in_took) begin
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (raw_bytes.size() > 0) begin
        it = raw_bytes.pop_front();
        v = 1'b1;
        gap_left = calm ? 0 : idle_length();
      end
    end
    in_valid <= v;
    in_item <= it;
  end

  // sink stall, with one long hold on request
  always @(negedge clk) begin
    logic s;
    int   n;
    if (hold_left > 0) begin
      hold_left--;
      s = 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      s = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      s = 1'b1;
    end else begin
      n = calm ? 0 : idle_length();
      stall_left = (n > 0) ? n - 1 : 0;
      s = (n > 0);
    end
    out_stall <= s;
  end

  // monitor: check the result, then predict from the accepted byte
  always @(posedge clk) begin
    sfd_out_t want;
    sfd_out_t next_out;
    bit       produced;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        outputs_seen++;
        if (frame_outputs.size() == 0) begin
          $error("output with nothing pending: kind %0d status %0d",
                 out_item.kind, out_item.status);
          fail_count++;
        end else begin
          want = frame_outputs.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_item.kind));
          check_field("payload_byte", 16'(want.payload_byte), 16'(out_item.payload_byte));
          check_field("source_address", want.source_address, out_item.source_address);
          check_field("dest_address", want.dest_address, out_item.dest_address);
          check_field("payload_length", 16'(want.payload_length),
                      16'(out_item.payload_length));
          check_field("status", 16'(want.status), 16'(out_item.status));
        end
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        bytes_accepted++;
        decode_byte(in_item, produced, next_out);
        if (produced) frame_outputs.push_back(next_out);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    sfd_in_t it;
    it.raw_byte = b;
    it.last_byte = last;
    raw_bytes.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    if (r == x) r = x + 8'd1;
    return r;
  endfunction

  task automatic queue_frame(input int plen, input frame_fault_t fault);
    logic [7:0]  bytes[$];
    logic [7:0]  data;
    logic [7:0]  b;
    logic [15:0] crc;
    int          ndata;
    int          esc_at;
    int          cut;
    crc = CRC_INIT;
    // after a length error nothing more is read, so keep the tail short
    ndata = (fault == FL_LEN && plen > 4) ? 4 : plen;
    esc_at = (fault == FL_ESC) ? $urandom_range(0, plen - 1) : -1;
    bytes.push_back((fault == FL_START) ? other_than(cfg_start) : cfg_start);
    repeat (4) bytes.push_back(8'($urandom_range(0, 255)));
    bytes.push_back(plen[7:0]);
    for (int i = 0; i < ndata; i++) begin
      if (i == esc_at) begin
        bytes.push_back(cfg_escape);
        b = 8'($urandom_range(0, 255));
        while (is_special(b ^ STUFF_MASK)) b = b + 8'd1;
        bytes.push_back(b);
      end
      case ($urandom_range(0, 7))
        0: data = cfg_start;
        1: data = cfg_end;
        2: data = cfg_escape;
        default: data = 8'($urandom_range(0, 255));
      endcase
      // start and end chars may also travel unescaped
      if (data == cfg_escape || (is_special(data) && $urandom_range(0, 1))) begin
        bytes.push_back(cfg_escape);
        bytes.push_back(data ^ STUFF_MASK);
      end else begin
        bytes.push_back(data);
      end
      crc = crc16_step(crc, data);
    end
    if (fault == FL_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    bytes.push_back(crc[15:8]);
    bytes.push_back(crc[7:0]);
    bytes.push_back((fault == FL_END) ? other_than(cfg_end) : cfg_end);
    if (fault == FL_LONG) begin
      repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom_range(0, 255)));
    end
    cut = bytes.size();
    if (fault == FL_TRUNC) cut = $urandom_range(1, bytes.size() - 1);
    for (int i = 0; i < cut; i++) push_byte(bytes[i], i == cut - 1);
  endtask

  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  task automatic random_traffic(input int target);
    int           goal;
    int           r;
    int           mx;
    int           plen;
    frame_fault_t fault;
    goal = bytes_queued + target;
    mx = int'(cfg_max);
    while (bytes_queued < goal) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) plen = $urandom_range(0, (mx < 40) ? mx : 40);
      else plen = $urandom_range(0, (mx < 10) ? mx : 10);
      if (r < 55) fault = FL_NONE;
      else if (r < 61) fault = FL_START;
      else if (r < 67) fault = FL_LEN;
      else if (r < 73) fault = FL_ESC;
      else if (r < 79) fault = FL_END;
      else if (r < 85) fault = FL_CRC;
      else if (r < 91) fault = FL_TRUNC;
      else if (r < 96) fault = FL_LONG;
      else fault = FL_NOISE;
      if (fault == FL_LEN) begin
        if (mx == 255) fault = FL_NONE;
        else plen = $urandom_range(mx + 1, 255);
      end
      if (fault == FL_ESC && plen == 0) begin
        if (mx == 0) fault = FL_NONE;
        else plen = 1;
      end
      if (fault == FL_NOISE) queue_noise($urandom_range(1, 6));
      else queue_frame(plen, fault);
    end
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_CHAR:  cfg_start = val;
      REG_END_CHAR:    cfg_end = val;
      REG_ESCAPE_CHAR: cfg_escape = val;
      REG_MAX_PAYLOAD: cfg_max = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] s, input logic [7:0] e,
                               input logic [7:0] esc, input logic [7:0] mx);
    write_reg(REG_START_CHAR, s);
    write_reg(REG_END_CHAR, e);
    write_reg(REG_ESCAPE_CHAR, esc);
    write_reg(REG_MAX_PAYLOAD, mx);
    settings_used++;
    @(posedge clk);
  endtask

  // wait until every byte is taken and every output has come back
  task automatic drain();
    int waited;
    waited = 0;
    while ((raw_bytes.size() != 0 || in_valid || frame_outputs.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] crc;
    cfg_start = 8'd123;
    cfg_end = 8'd124;
    cfg_escape = 8'd125;
    cfg_max = 8'd255;
    clear_frame_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings_used = 1;

    // empty payload, so the crc bytes are the initial value
    push_byte(cfg_start, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(CRC_INIT[15:8], 1'b0);
    push_byte(CRC_INIT[7:0], 1'b0);
    push_byte(cfg_end, 1'b1);
    // escaped escape char, bare start char, top byte value
    crc = crc16_step(crc16_step(crc16_step(CRC_INIT, cfg_escape), cfg_start), 8'hFF);
    push_byte(cfg_start, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'd3, 1'b0);
    push_byte(cfg_escape, 1'b0);
    push_byte(cfg_escape ^ STUFF_MASK, 1'b0);
    push_byte(cfg_start, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(crc[15:8], 1'b0);
    push_byte(crc[7:0], 1'b0);
    push_byte(cfg_end, 1'b1);
    // wrong first byte, then a buffer that stops right after the start char
    push_byte(8'h00, 1'b1);
    push_byte(cfg_start, 1'b1);
    queue_frame(120, FL_NONE);
    random_traffic(70);
    drain();

    write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
    apply_setting(8'h00, 8'hFF, 8'h20, 8'h00);
    random_traffic(50);
    drain();

    calm = 1'b1;
    apply_setting(8'hFF, 8'h00, 8'hDF, 8'hFF);
    random_traffic(50);
    drain();
    calm = 1'b0;

    // long sink hold while bytes keep coming
    hold_req = 1'b1;
    apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(1, 30)));
    random_traffic(60);
    drain();

    apply_setting(8'h7E, 8'h7E, 8'h7D, 8'h0C);
    random_traffic(50);
    drain();
    repeat (5) @(posedge clk);

    if (frame_outputs.size() != 0) begin
      $error("%0d decoder outputs never arrived", frame_outputs.size());
      fail_count++;
    end
    $display("run covered %0d raw bytes and %0d decoder outputs over %0d register settings",
             bytes_accepted, outputs_seen, settings_used);
    $display("%0d mismatches, one long sink hold with the input backed up", fail_count);
    if (fail_count == 0) begin
      $display("stuffed_frame_decoder_crc16 verification clean");
    end else begin
      $display("stuffed_frame_decoder_crc16 verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("stuffed_frame_decoder_crc16 verification failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/sfd_pkg.sv
sv/stuffed_frame_decoder_crc16.sv
tb/sv/stuffed_frame_decoder_crc16_tb.sv
